FILE: design/mrf_pkg.sv
// message ring fifo package: status and command codes, fixed field widths
// no dependencies
`default_nettype none

package mrf_pkg;

    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [OCC_W-1:0]    occ_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_OVERFLOW = 2'd1;
    localparam status_t ST_LENGTH   = 2'd2;
    localparam status_t ST_UNDERRUN = 2'd3;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

endpackage

`default_nettype wire

FILE: design/message_ring_fifo_top.sv
// message ring fifo top level: sequencer plus payload and length rams
// depends on mrf_pkg, mrf_ram, mrf_ctrl
`default_nettype none

// Ring FIFO of byte messages held in DEPTH slots of BUF_SIZE bytes; one slot
// stays empty, so up to DEPTH-1 messages are stored. Each push transaction
// carries one byte; only the byte marked last_byte produces a result (ok,
// overflow or length limit) and the message is kept or dropped whole. A pop
// transaction reads the head length from the length ram, then streams the
// message from the payload ram: the first byte is fetched once the length is
// read, one byte follows per cycle while the output is not stalled, and the
// input stays closed until the last byte is loaded into the output register;
// an underrun, a refusal or an empty message gives its one result from the
// length state and keeps the input closed until that result is loaded. Both
// rams have a registered read port, which sets the pop start-up delay. The
// stores power up undefined and need no clearing pass: only committed slots
// are ever read. A registered output stage lets the next transaction be taken
// while a result is pending.
module message_ring_fifo_top
    import mrf_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int BUF_SIZE = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    cmd,
    input  wire byte_t   data_byte,
    input  wire logic    last_byte,
    input  wire len_t    len_limit,
    output logic         out_valid,
    input  wire logic    out_ready,
    output status_t      status,
    output occ_t         occupancy,
    output byte_t        out_byte,
    output logic         has_byte,
    output len_t         msg_length,
    output logic         last_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int AW = $clog2(DEPTH * BUF_SIZE);

    logic          pay_we;
    logic [AW-1:0] pay_waddr;
    byte_t         pay_wdata;
    logic          pay_re;
    logic [AW-1:0] pay_raddr;
    byte_t         pay_rdata;
    logic          len_we;
    logic [IW-1:0] len_waddr;
    len_t          len_wdata;
    logic          len_re;
    logic [IW-1:0] len_raddr;
    len_t          len_rdata;

    mrf_ctrl #(
        .DEPTH    (DEPTH),
        .BUF_SIZE (BUF_SIZE),
        .IW       (IW),
        .AW       (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .len_limit   (len_limit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .occupancy   (occupancy),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .msg_length  (msg_length),
        .last_result (last_result),
        .pay_we      (pay_we),
        .pay_waddr   (pay_waddr),
        .pay_wdata   (pay_wdata),
        .pay_re      (pay_re),
        .pay_raddr   (pay_raddr),
        .pay_rdata   (pay_rdata),
        .len_we      (len_we),
        .len_waddr   (len_waddr),
        .len_wdata   (len_wdata),
        .len_re      (len_re),
        .len_raddr   (len_raddr),
        .len_rdata   (len_rdata)
    );

    mrf_ram #(
        .WIDTH   (BYTE_W),
        .ADDR_W  (AW),
        .DEPTH_N (DEPTH * BUF_SIZE)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    mrf_ram #(
        .WIDTH   (LEN_W),
        .ADDR_W  (IW),
        .DEPTH_N (DEPTH)
    ) u_length_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

endmodule

`default_nettype wire

FILE: design/mrf_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// read data holds while read enable is low; no package dependency
`default_nettype none

module mrf_ram #(
    parameter int WIDTH   = 8,
    parameter int ADDR_W  = 4,
    parameter int DEPTH_N = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH_N];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/mrf_ctrl.sv
// message ring fifo sequencer: ring indexes, push bookkeeping, pop streaming
// and the output register; drives the payload and length rams; uses mrf_pkg
`default_nettype none

module mrf_ctrl
    import mrf_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int BUF_SIZE = 64,
    parameter int IW       = 4,
    parameter int AW       = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          cmd,
    input  wire byte_t         data_byte,
    input  wire logic          last_byte,
    input  wire len_t          len_limit,
    output logic               out_valid,
    input  wire logic          out_ready,
    output status_t            status,
    output occ_t               occupancy,
    output byte_t              out_byte,
    output logic               has_byte,
    output len_t               msg_length,
    output logic               last_result,
    output logic               pay_we,
    output logic      [AW-1:0] pay_waddr,
    output byte_t              pay_wdata,
    output logic               pay_re,
    output logic      [AW-1:0] pay_raddr,
    input  wire byte_t         pay_rdata,
    output logic               len_we,
    output logic      [IW-1:0] len_waddr,
    output len_t               len_wdata,
    output logic               len_re,
    output logic      [IW-1:0] len_raddr,
    input  wire len_t          len_rdata
);

    localparam int CW  = $clog2(BUF_SIZE + 1);
    localparam int OCW = (IW > OCC_W) ? IW : OCC_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [OCW-1:0] occ_of(input logic [IW-1:0] h,
                                               input logic [IW-1:0] t);
        logic [OCW-1:0] d;
        d = OCW'(t) - OCW'(h);
        if (t < h)
        begin
            d = d + OCW'(DEPTH);
        end
        return d;
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] wc_reg, wc_next;
    logic          drop_reg, drop_next;
    len_t          maxlen_reg, maxlen_next;
    len_t          plen_reg, plen_next;
    len_t          idx_reg, idx_next;
    logic [AW-1:0] rd_base_reg, rd_base_next;
    logic          out_valid_reg, out_valid_next;

    status_t       status_reg, status_next;
    logic [OCW-1:0] occ_reg, occ_next;
    byte_t         byte_reg, byte_next;
    logic          has_reg, has_next;
    len_t          len_reg, len_next;
    logic          last_reg, last_next;

    logic          can_load;
    logic          load;
    logic          accept;
    logic          room;
    len_t          len_c;
    logic [AW-1:0] head_base;
    logic [AW-1:0] tail_base;

    assign head_base = AW'(head_reg) * AW'(BUF_SIZE);
    assign tail_base = AW'(tail_reg) * AW'(BUF_SIZE);
    assign can_load  = !out_valid_reg || out_ready;
    // a push byte that is not the last one needs no room in the output register
    assign in_ready  = (state_reg == S_IDLE) &&
                       (can_load || !((cmd == CMD_PUSH) && last_byte));
    assign accept    = in_valid && in_ready;
    assign room      = wc_reg < CW'(BUF_SIZE);
    assign len_c     = (len_rdata > LEN_W'(BUF_SIZE)) ? LEN_W'(BUF_SIZE) : len_rdata;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        wc_next      = wc_reg;
        drop_next    = drop_reg;
        maxlen_next  = maxlen_reg;
        plen_next    = plen_reg;
        idx_next     = idx_reg;
        rd_base_next = rd_base_reg;

        pay_we    = 1'b0;
        pay_waddr = tail_base + AW'(wc_reg);
        pay_wdata = data_byte;
        pay_re    = 1'b0;
        pay_raddr = head_base;
        len_we    = 1'b0;
        len_waddr = tail_reg;
        len_wdata = LEN_W'(wc_reg) + LEN_W'(1);
        len_re    = 1'b0;
        len_raddr = head_reg;

        load        = 1'b0;
        status_next = ST_OK;
        occ_next    = occ_of(head_reg, tail_reg);
        byte_next   = '0;
        has_next    = 1'b0;
        len_next    = '0;
        last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_PUSH)
                    begin
                        if (room)
                        begin
                            pay_we  = 1'b1;
                            wc_next = wc_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        if (last_byte)
                        begin
                            load = 1'b1;
                            if (occ_of(head_reg, tail_reg) == OCW'(DEPTH - 1))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else if (drop_reg || !room)
                            begin
                                status_next = ST_LENGTH;
                            end
                            else
                            begin
                                len_we    = 1'b1;
                                tail_next = inc_idx(tail_reg);
                                occ_next  = occ_of(head_reg, inc_idx(tail_reg));
                            end
                            wc_next   = '0;
                            drop_next = 1'b0;
                        end
                    end
                    else
                    begin
                        maxlen_next = len_limit;
                        len_re      = 1'b1;
                        state_next  = S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                if (can_load)
                begin
                    if (head_reg == tail_reg)
                    begin
                        load        = 1'b1;
                        status_next = ST_UNDERRUN;
                        occ_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else if (len_c > maxlen_reg)
                    begin
                        load        = 1'b1;
                        status_next = ST_LENGTH;
                        len_next    = len_c;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        head_next = inc_idx(head_reg);
                        if (len_c == '0)
                        begin
                            load       = 1'b1;
                            occ_next   = occ_of(inc_idx(head_reg), tail_reg);
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // fetch the first byte, the stream follows one per cycle while the output is not stalled
                            pay_re       = 1'b1;
                            pay_raddr    = head_base;
                            rd_base_next = head_base;
                            plen_next    = len_c;
                            idx_next     = '0;
                            state_next   = S_STREAM;
                        end
                    end
                end
            end
            S_STREAM:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    byte_next = pay_rdata;
                    has_next  = 1'b1;
                    len_next  = plen_reg;
                    last_next = (idx_reg + 1'b1) == plen_reg;
                    if ((idx_reg + 1'b1) == plen_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        pay_re    = 1'b1;
                        pay_raddr = rd_base_reg + AW'(idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            wc_reg        <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wc_reg        <= wc_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maxlen_reg  <= maxlen_next;
        plen_reg    <= plen_next;
        idx_reg     <= idx_next;
        rd_base_reg <= rd_base_next;
        if (load)
        begin
            status_reg <= status_next;
            occ_reg    <= occ_next;
            byte_reg   <= byte_next;
            has_reg    <= has_next;
            len_reg    <= len_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign occupancy   = occ_reg[OCC_W-1:0];
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign msg_length  = len_reg;
    assign last_result = last_reg;

endmodule

`default_nettype wire

FILE: design/mrf_checker.sv
// port-level checks for the message ring fifo and the bind that attaches them
// depends on mrf_pkg and message_ring_fifo_top
`default_nettype none

module mrf_checker
    import mrf_pkg::*;
#(
    parameter int BUF_SIZE = 64
) (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire status_t status,
    input wire occ_t    occupancy,
    input wire byte_t   out_byte,
    input wire logic    has_byte,
    input wire len_t    msg_length,
    input wire logic    last_result
);

    // a stalled result keeps its byte and marker
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_result))
        else $error("result changed while stalled");

    // streamed bytes only come with ok status and a real length
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> status == ST_OK && msg_length != '0 &&
                                  msg_length <= LEN_W'(BUF_SIZE))
        else $error("message byte with bad status or length");

    // any result without a byte is a single, final result
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last_result && out_byte == '0)
        else $error("non-byte result not final");

    // underrun reports an empty ring
    a_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNDERRUN |-> occupancy == '0 && msg_length == '0)
        else $error("underrun with nonzero occupancy or length");

    // after a non-final byte is taken the next result continues the stream
    a_stream_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && has_byte && !last_result |=> has_byte ||
                                                               !out_valid)
        else $error("message stream broken");

endmodule

bind message_ring_fifo_top mrf_checker #(
    .BUF_SIZE (BUF_SIZE)
) u_mrf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .occupancy   (occupancy),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .msg_length  (msg_length),
    .last_result (last_result)
);

`default_nettype wire
